// ===== src/pci_bar_window_allocator_assert.svh =====
// assertion macros shared by the allocator modules
// no dependencies; included by files that carry assertions
`ifndef PCI_BAR_WINDOW_ALLOCATOR_ASSERT_SVH
`define PCI_BAR_WINDOW_ALLOCATOR_ASSERT_SVH

// checked only outside reset
`define PBWA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pbwa assertion failed");

// checked during reset too
`define PBWA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pbwa assertion failed");

`endif

// ===== src/pbwa_pkg.sv =====
// package for the pci bar window allocator: constants, status codes, queue item
// no dependencies
package pbwa_pkg;

  localparam int unsigned WINDOW_BYTES = 1048576;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned SLOT_COUNT   = 6;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned ATTR_W = 4;

  // reservation width covers the larger of window and page
  localparam int unsigned ALLOC_MAX =
    (WINDOW_BYTES > PAGE_BYTES) ? WINDOW_BYTES : PAGE_BYTES;
  localparam int unsigned ALLOC_W = $clog2(ALLOC_MAX + 1);

  localparam logic [ADDR_W-1:0] WINDOW_BASE_RST = 32'h4000_0000;
  localparam logic [ADDR_W-1:0] ALL_ONES        = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_ASSIGNED   = 3'd0,
    ST_UNIMPL     = 3'd1,
    ST_IO         = 3'd2,
    ST_RESERVED   = 3'd3,
    ST_WIDE_LAST  = 3'd4,
    ST_BAD_SIZE   = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  // classified probe waiting for allocation
  typedef struct packed {
    logic               first;
    logic               wide;
    status_t            status;   // ST_ASSIGNED here means size checks passed
    logic [SIZE_W-1:0]  size;
    logic [ALLOC_W-1:0] alloc;
    logic [ALLOC_W-1:0] alloc_mask;
    logic [ATTR_W-1:0]  attr;
  } pbwa_item_t;

endpackage

// ===== src/pbwa_if.sv =====
// valid/ready channel interfaces for probe items and allocation results
// depends on pbwa_pkg
interface pbwa_in_if import pbwa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              first_of_function;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] original_value;
  logic [ADDR_W-1:0] probe_low;
  logic [ADDR_W-1:0] probe_high;

  modport source (output valid, first_of_function, slot, original_value, probe_low,
                  probe_high, input ready);
  modport sink (input valid, first_of_function, slot, original_value, probe_low,
                probe_high, output ready);
endinterface

interface pbwa_out_if import pbwa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] assigned_address;
  logic [SIZE_W-1:0] decode_size;
  logic [ATTR_W-1:0] attributes;
  logic              consumes_next_slot;

  modport source (output valid, status, assigned_address, decode_size, attributes,
                  consumes_next_slot, input ready);
  modport sink (input valid, status, assigned_address, decode_size, attributes,
                consumes_next_slot, output ready);
endinterface

// ===== src/pci_bar_window_allocator.sv =====
// channel    | dir | handshake      | payload
// in_ch      | in  | valid/ready    | first_of_function, slot, original_value, probes
// out_ch     | out | valid/ready    | status, assigned_address, decode_size, attributes,
//            |     |                | consumes_next_slot
// cfg        | in  | cfg_wr_en      | cfg_wr_data (window_base)
//
// one item per cycle sustained while out_ch.ready is high; a result is offered after the edge
// that follows its transfer at the earliest, having passed the queue and then the output register
// the back end's free pointer update (align add, end add, window compare) sets the cycle
// a two-entry queue parts front and back; in_ch.ready drops only when it is full
// a stalled result holds in the output register while the queue keeps filling
// rst is synchronous: queue empty, no result pending, free pointer zero, base 0x40000000
//
// top level of the pci bar window allocator; depends on pbwa_pkg, pbwa_if and submodules
module pci_bar_window_allocator import pbwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  pbwa_in_if.sink           in_ch,
  pbwa_out_if.source        out_ch
);

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  pbwa_item_t wr_item;
  pbwa_item_t rd_item;

  pbwa_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (wr_item)
  );

  pbwa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (rd_item),
    .pop     (pop)
  );

  pbwa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (rd_item),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== src/pbwa_front.sv =====
// front end: accepts probe items, checks type and decode size, builds queue items
// depends on pbwa_pkg and pbwa_in_if
module pbwa_front import pbwa_pkg::*; (
  pbwa_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push,
  output pbwa_item_t  item
);

  logic              wide;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] extent;
  logic              size_ok;
  logic [ALLOC_W-1:0] alloc;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    wide = (in_ch.original_value[2:1] == 2'b10);
    lo   = {in_ch.probe_low[ADDR_W-1:4], 4'b0000};
    hi   = wide ? in_ch.probe_high : ALL_ONES;
    // size below 2^32 only when the upper word is all ones and lo is nonzero
    extent  = ~lo + 32'd1;
    size_ok = (hi == ALL_ONES) && (lo != '0) &&
              (extent <= ADDR_W'(WINDOW_BYTES)) && ((extent & (extent - 32'd1)) == '0);
    if (extent < ADDR_W'(PAGE_BYTES)) begin
      alloc = ALLOC_W'(PAGE_BYTES);
    end else begin
      alloc = extent[ALLOC_W-1:0];
    end

    item.first      = in_ch.first_of_function;
    item.wide       = wide;
    item.size       = extent[SIZE_W-1:0];
    item.alloc      = alloc;
    item.alloc_mask = alloc - ALLOC_W'(1);
    item.attr       = in_ch.original_value[ATTR_W-1:0];

    if (in_ch.original_value[0]) begin
      item.status = ST_IO;
    end else if (in_ch.original_value[2:1] != 2'b00 && !wide) begin
      item.status = ST_RESERVED;
    end else if (wide && in_ch.slot >= SLOT_W'(SLOT_COUNT - 1)) begin
      item.status = ST_WIDE_LAST;
    end else if (lo == '0 && !wide) begin
      item.status = ST_UNIMPL;
    end else if (!size_ok) begin
      item.status = ST_BAD_SIZE;
    end else begin
      item.status = ST_ASSIGNED;
    end
  end

endmodule

// ===== src/pbwa_queue.sv =====
// two-entry queue of classified items between front and back
// depends on pbwa_pkg and the assertion header
`include "pci_bar_window_allocator_assert.svh"

module pbwa_queue import pbwa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pbwa_item_t wr_item,
  output logic       full,
  output logic       valid,
  output pbwa_item_t rd_item,
  input  logic       pop
);

  pbwa_item_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `PBWA_ASSERT(a_count_bound, clk, rst, count <= 2'd2)
  `PBWA_ASSERT(a_ptr_match, clk, rst, (count == 2'd1) |-> (wr_ptr != rd_ptr))
  `PBWA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (count == 2'd0 && wr_ptr == rd_ptr))

endmodule

// ===== src/pbwa_back.sv =====
// back end: holds the free pointer and window base, places reservations, drives results
// depends on pbwa_pkg, pbwa_out_if and the assertion header
`include "pci_bar_window_allocator_assert.svh"

module pbwa_back import pbwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  logic              q_valid,
  input  pbwa_item_t        q_item,
  output logic              pop,
  pbwa_out_if.source        out_ch
);

  logic [ADDR_W-1:0] window_base;
  logic [ADDR_W+1:0] window_limit;
  logic [ADDR_W:0]   next_free;
  logic [ADDR_W:0]   next_free_next;

  logic [ADDR_W:0]   base;
  logic [ADDR_W+1:0] aligned;
  logic [ADDR_W+2:0] alloc_end;
  logic              fits;
  status_t           res_status;

  logic              o_valid;
  status_t           o_status;
  logic [ADDR_W-1:0] o_addr;
  logic [SIZE_W-1:0] o_size;
  logic [ATTR_W-1:0] o_attr;
  logic              o_next;

  logic              o_zero;
  logic              o_page_ok;

  assign pop = q_valid && (!o_valid || out_ch.ready);

  always_comb begin
    // a first item restarts at the window base even when it fails
    base      = q_item.first ? {1'b0, window_base} : next_free;
    aligned   = ({1'b0, base} + (ADDR_W+2)'(q_item.alloc_mask)) &
                ~((ADDR_W+2)'(q_item.alloc_mask));
    alloc_end = {1'b0, aligned} + (ADDR_W+3)'(q_item.alloc);
    fits      = (alloc_end <= {1'b0, window_limit}) &&
                (alloc_end <= (ADDR_W+3)'(35'h1_0000_0000));
    res_status     = q_item.status;
    next_free_next = base;
    if (q_item.status == ST_ASSIGNED) begin
      if (fits) begin
        next_free_next = alloc_end[ADDR_W:0];
      end else begin
        res_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= WINDOW_BASE_RST;
      window_limit <= {2'b00, WINDOW_BASE_RST} + (ADDR_W+2)'(WINDOW_BYTES);
      next_free    <= '0;
      o_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_base  <= cfg_wr_data;
        window_limit <= {2'b00, cfg_wr_data} + (ADDR_W+2)'(WINDOW_BYTES);
      end
      if (pop) begin
        next_free <= next_free_next;
        o_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      o_status <= res_status;
      if (res_status == ST_ASSIGNED) begin
        o_addr <= aligned[ADDR_W-1:0];
        o_size <= q_item.size;
        o_attr <= q_item.attr;
        o_next <= q_item.wide;
      end else begin
        o_addr <= '0;
        o_size <= '0;
        o_attr <= '0;
        o_next <= 1'b0;
      end
    end
  end

  assign out_ch.valid              = o_valid;
  assign out_ch.status             = o_status;
  assign out_ch.assigned_address   = o_addr;
  assign out_ch.decode_size        = o_size;
  assign out_ch.attributes         = o_attr;
  assign out_ch.consumes_next_slot = o_next;

  assign o_zero    = (o_addr == '0) && (o_size == '0) && (o_attr == '0) && !o_next;
  assign o_page_ok = ((o_addr & ADDR_W'(PAGE_BYTES - 1)) == '0);

  `PBWA_ASSERT(a_fail_zero, clk, rst, (o_valid && o_status != ST_ASSIGNED) |-> o_zero)
  `PBWA_ASSERT(a_page_aligned, clk, rst, (o_valid && o_status == ST_ASSIGNED) |-> o_page_ok)
  `PBWA_ASSERT(a_ptr_hold, clk, rst, (!pop && !$past(rst)) |=> (next_free == $past(next_free)))

endmodule

// ===== tb/pci_bar_window_allocator_tb.sv =====
// self-checking testbench for pci_bar_window_allocator: directed probe table, then random
// register sets under several window bases with random idling and a long output stall
// depends on pbwa_pkg, pbwa_if and the allocator rtl
`timescale 1ns / 100ps

module pci_bar_window_allocator_tb;
  import pbwa_pkg::*;

  typedef struct packed {
    logic              first;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] orig;
    logic [ADDR_W-1:0] plow;
    logic [ADDR_W-1:0] phigh;
  } bar_probe_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [ATTR_W-1:0] attr;
    logic              pair;
  } bar_grant_t;

  typedef struct {
    bar_probe_t probe;
    bit         typed;
    bar_grant_t grant;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;

  pbwa_in_if  in_ch ();
  pbwa_out_if out_ch ();

  pci_bar_window_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #6 clk = ~clk;

  // allocator state as the block should hold it
  logic [ADDR_W-1:0] win_base;
  logic [32:0]       free_ptr;

  bar_grant_t  pending_grants[$];
  stim_row_t   stim_table[$];
  int unsigned tx_idle_max = 7;
  int unsigned rx_idle_max = 7;
  int unsigned squeeze_cycles = 0;
  int unsigned probes_sent = 0;
  int unsigned grants_seen = 0;
  int unsigned mismatches = 0;
  int unsigned input_stalls = 0;
  int unsigned base_settings = 1;
  int unsigned status_seen[7];

  function automatic bar_grant_t allocate_bar(bar_probe_t p);
    bar_grant_t  g;
    logic        wide;
    logic [63:0] lo, hi, extent, resv, aligned, stop;
    g = '0;
    g.status = ST_ASSIGNED;
    wide = (p.orig[2:1] == 2'b10);
    if (p.first) free_ptr = {1'b0, win_base};
    if (p.orig[0]) begin
      g.status = ST_IO;
    end else if (p.orig[2:1] != 2'b00 && !wide) begin
      g.status = ST_RESERVED;
    end else if (wide && p.slot >= SLOT_COUNT - 1) begin
      g.status = ST_WIDE_LAST;
    end else begin
      lo = {32'h0, p.plow[31:4], 4'h0};
      hi = wide ? {32'h0, p.phigh} : {32'h0, ALL_ONES};
      if (lo == 64'h0 && !wide) begin
        g.status = ST_UNIMPL;
      end else begin
        extent = ~((hi << 32) | lo) + 64'd1;
        if (extent == 64'h0 || extent > 64'(WINDOW_BYTES) ||
            (extent & (extent - 64'd1)) != 64'h0) begin
          g.status = ST_BAD_SIZE;
        end else begin
          // at least a page is reserved, aligned to its own size
          resv = (extent < 64'(PAGE_BYTES)) ? 64'(PAGE_BYTES) : extent;
          aligned = (64'(free_ptr) + resv - 64'd1) & ~(resv - 64'd1);
          stop = aligned + resv;
          if (stop > 64'(win_base) + 64'(WINDOW_BYTES) || stop > 64'h1_0000_0000) begin
            g.status = ST_FULL;
          end else begin
            g.addr = aligned[31:0];
            g.size = extent[SIZE_W-1:0];
            g.attr = p.orig[3:0];
            g.pair = wide;
            free_ptr = stop[32:0];
          end
        end
      end
    end
    return g;
  endfunction

  function automatic void add_row(logic first, logic [2:0] slot, logic [31:0] orig,
                                  logic [31:0] plow, logic [31:0] phigh, bit typed,
                                  status_t st, logic [31:0] addr, logic [20:0] size,
                                  logic [3:0] attr, logic pair);
    stim_row_t r;
    r.probe = '{first, slot, orig, plow, phigh};
    r.typed = typed;
    r.grant = '{st, addr, size, attr, pair};
    stim_table.push_back(r);
  endfunction

  function automatic bar_probe_t random_bar(logic first, logic [2:0] slot);
    bar_probe_t  p;
    int unsigned kind, lg, r;
    logic [31:0] rnd;
    logic [63:0] mask;
    logic        pf;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    rnd = $urandom;
    pf = $urandom_range(0, 1);
    if (r < 70) lg = $urandom_range(4, 12);
    else if (r < 95) lg = $urandom_range(13, 17);
    else lg = $urandom_range(18, 20);
    p.first = first;
    p.slot = slot;
    p.orig = {rnd[31:4], pf, 3'b000};
    p.phigh = $urandom;
    if (kind < 60) begin
      // well-formed memory register, 64-bit for a third of them
      mask = ~((64'd1 << lg) - 64'd1);
      if (kind >= 40) begin
        p.orig[2:1] = 2'b10;
        p.phigh = mask[63:32];
      end
      p.plow = {mask[31:4], 4'(rnd)};
    end else if (kind < 66) begin
      p.plow = {28'h0, 4'(rnd)};
    end else if (kind < 72) begin
      p.orig[0] = 1'b1;
      p.plow = $urandom;
    end else if (kind < 77) begin
      p.orig[2:1] = pf ? 2'b01 : 2'b11;
      p.plow = $urandom;
    end else if (kind < 87) begin
      // too large or not a power of two
      if (r[0]) begin
        p.orig[2:1] = 2'b10;
        mask = ~((64'd1 << $urandom_range(21, 63)) - 64'd1);
        p.phigh = mask[63:32];
        p.plow = mask[31:0];
      end else if (r[1]) begin
        mask = ~((64'd1 << $urandom_range(21, 31)) - 64'd1);
        p.plow = mask[31:0];
      end else begin
        p.plow = $urandom;
      end
    end else begin
      p.first = $urandom_range(0, 1);
      p.slot = $urandom_range(0, 7);
      p.orig = $urandom;
      p.plow = $urandom;
    end
    return p;
  endfunction

  task automatic offer_probe(bar_probe_t p, bit typed, bar_grant_t typed_grant);
    bar_grant_t  predicted;
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_of_function <= p.first;
    in_ch.slot <= p.slot;
    in_ch.original_value <= p.orig;
    in_ch.probe_low <= p.plow;
    in_ch.probe_high <= p.phigh;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    // transfer taken at this edge
    predicted = allocate_bar(p);
    pending_grants.push_back(typed ? typed_grant : predicted);
    probes_sent++;
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned sent;
    int unsigned s;
    bar_probe_t  p;
    logic        first;
    sent = 0;
    while (sent < count) begin
      // one function's registers; most functions start a new allocation at their first one
      first = ($urandom_range(0, 9) != 0);
      s = 0;
      while (s < SLOT_COUNT && sent < count) begin
        p = random_bar(first, 3'(s));
        offer_probe(p, 1'b0, '0);
        sent++;
        first = 1'b0;
        s += (p.orig[2:0] == 3'b100) ? 2 : 1;
      end
    end
  endtask

  task automatic write_window_base(logic [ADDR_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_base = value;
    base_settings++;
  endtask

  // result checker and input stall count, sampled between edges
  always @(negedge clk) begin
    bar_grant_t exp_g;
    if (!rst && in_ch.valid && !in_ch.ready) input_stalls++;
    if (!rst && out_ch.valid && out_ch.ready) begin
      grants_seen++;
      if (out_ch.status < 3'd7) status_seen[out_ch.status]++;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d addr %h", out_ch.status,
                   out_ch.assigned_address);
      end else begin
        exp_g = pending_grants.pop_front();
        if (out_ch.status !== exp_g.status || out_ch.assigned_address !== exp_g.addr ||
            out_ch.decode_size !== exp_g.size || out_ch.attributes !== exp_g.attr ||
            out_ch.consumes_next_slot !== exp_g.pair) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: exp %s %h %h %h %b, got %0d %h %h %h %b",
                     grants_seen, exp_g.status.name(), exp_g.addr, exp_g.size,
                     exp_g.attr, exp_g.pair, out_ch.status, out_ch.assigned_address,
                     out_ch.decode_size, out_ch.attributes, out_ch.consumes_next_slot);
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off when asked
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (squeeze_cycles != 0) begin
        stall = squeeze_cycles;
        squeeze_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_idle_max);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] bases[7];
    int unsigned       ph;
    logic [31:0]       rnd;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.first_of_function = 1'b0;
    in_ch.slot = '0;
    in_ch.original_value = '0;
    in_ch.probe_low = '0;
    in_ch.probe_high = '0;
    win_base = WINDOW_BASE_RST;
    free_ptr = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    rnd = $urandom;
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hfff0_0000;   // window ends exactly at 4 GiB
    bases[2] = 32'hffff_ffff;
    bases[3] = {rnd[31:12], 12'h000};
    bases[4] = $urandom;
    bases[5] = 32'h7fff_f800;
    bases[6] = WINDOW_BASE_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // pointer still zero after reset, no first register yet
    add_row(1'b0, 3'd0, 32'h0, 32'hffff_f000, 32'h0, 1'b1,
            ST_ASSIGNED, 32'h0, 21'h1000, 4'h0, 1'b0);
    add_row(1'b1, 3'd0, 32'h8, 32'hfff0_0000, 32'h0, 1'b1,
            ST_ASSIGNED, 32'h4000_0000, 21'h10_0000, 4'h8, 1'b0);
    add_row(1'b0, 3'd1, 32'h0, 32'hffff_fff0, 32'h0, 1'b1,
            ST_FULL, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b1, 3'd0, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
            ST_IO, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd1, 32'h2, 32'hffff_f000, 32'h0, 1'b1,
            ST_RESERVED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd2, 32'h6, 32'hffff_f000, 32'h0, 1'b1,
            ST_RESERVED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd3, 32'hffff_ffff, 32'hffff_f000, 32'h0, 1'b1,
            ST_IO, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd5, 32'h4, 32'hffff_f000, 32'hffff_ffff, 1'b1,
            ST_WIDE_LAST, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd7, 32'hc, 32'hffff_f000, 32'hffff_ffff, 1'b1,
            ST_WIDE_LAST, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd3, 32'h0, 32'h0000_000f, 32'h0, 1'b1,
            ST_UNIMPL, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd0, 32'h0, 32'h0, 32'hffff_ffff, 1'b1,
            ST_UNIMPL, 32'h0, 21'h0, 4'h0, 1'b0);
    // 64-bit mask of zero wraps to a size of zero
    add_row(1'b0, 3'd0, 32'h4, 32'h0, 32'h0, 1'b1,
            ST_BAD_SIZE, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd0, 32'h4, 32'h0, 32'hffff_ffff, 1'b1,
            ST_BAD_SIZE, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd1, 32'h0, 32'hffff_5000, 32'h0, 1'b1,
            ST_BAD_SIZE, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd1, 32'h0, 32'hffe0_0000, 32'h0, 1'b1,
            ST_BAD_SIZE, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd4, 32'h4, 32'hffff_fff0, 32'hffff_fffe, 1'b1,
            ST_BAD_SIZE, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b1, 3'd0, 32'h0, 32'hffff_fff0, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd1, 32'hc, 32'hffff_f00c, 32'hffff_ffff, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd3, 32'h0, 32'hffff_8000, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd7, 32'hffff_fff0, 32'hffff_ffff, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd4, 32'h8, 32'hfff8_0000, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd5, 32'h0, 32'hfff8_0000, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b1, 3'd0, 32'h0, 32'hfff8_0000, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd1, 32'h0, 32'hfff8_0000, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);
    add_row(1'b0, 3'd2, 32'h0, 32'hffff_fff0, 32'h0, 1'b0,
            ST_ASSIGNED, 32'h0, 21'h0, 4'h0, 1'b0);

    foreach (stim_table[i]) offer_probe(stim_table[i].probe, stim_table[i].typed,
                                        stim_table[i].grant);
    run_phase(200);

    for (ph = 0; ph < 7; ph++) begin
      write_window_base(bases[ph]);
      case (ph % 4)
        0: begin tx_idle_max = 0; rx_idle_max = 0; end
        1: begin tx_idle_max = 7; rx_idle_max = 7; end
        2: begin tx_idle_max = 0; rx_idle_max = 7; end
        default: begin tx_idle_max = 7; rx_idle_max = 0; end
      endcase
      // back-pressure burst: output held while input keeps coming
      if (ph == 2) squeeze_cycles = 80;
      run_phase(200);
    end

    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d probes over %0d window bases, %0d results, %0d input stall cycles",
             probes_sent, base_settings, grants_seen, input_stalls);
    $display("assigned %0d, full %0d, bad size %0d, unimpl %0d, io %0d, rsvd %0d, wide %0d",
             status_seen[ST_ASSIGNED], status_seen[ST_FULL], status_seen[ST_BAD_SIZE],
             status_seen[ST_UNIMPL], status_seen[ST_IO], status_seen[ST_RESERVED],
             status_seen[ST_WIDE_LAST]);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
